// ===== design/hud_coverage_alpha_premultiply_assert.svh =====
// ---------------------------------------------------------------------------
// HUD coverage alpha premultiply - assertion macros
// Concurrent assertion helpers; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef HUD_COVERAGE_ALPHA_PREMULTIPLY_ASSERT_SVH
`define HUD_COVERAGE_ALPHA_PREMULTIPLY_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while rst_n is low.
`define HCA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hca assertion failed");
// Next-cycle implication, disabled while rst_n is low.
`define HCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hca assertion failed");
`else
`define HCA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define HCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/hca_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hca_pkg
// Types, constants and per-channel constant selectors for the overlay
// coverage-to-alpha and premultiply pipeline.
// ---------------------------------------------------------------------------
package hca_pkg;

    // Width of the configuration registers.
    localparam int CFG_W = 11;

    // Configuration register indexes.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd420;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd80;

    // Channel codes, also the lane index inside color_t.
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Base colors and alphas of the two pixel classes.
    localparam int BorderRed   = 52;
    localparam int BorderGreen = 58;
    localparam int BorderBlue  = 66;
    localparam int InnerRed    = 20;
    localparam int InnerGreen  = 23;
    localparam int InnerBlue   = 29;
    localparam int BorderAlpha = 208;
    localparam int InnerAlpha  = 176;
    localparam int TextAlpha   = 238;

    // Reciprocal scale: floor(x * M >> 24) equals floor(x / (2 * d)) for all
    // x below 2^15 when M is rounded up.
    localparam int RECIP_SHIFT = 24;
    localparam int RecipOne    = 2 ** RECIP_SHIFT;

    localparam int BorderDivRed   = 255 - BorderRed;
    localparam int BorderDivGreen = 255 - BorderGreen;
    localparam int BorderDivBlue  = 255 - BorderBlue;
    localparam int InnerDivRed    = 255 - InnerRed;
    localparam int InnerDivGreen  = 255 - InnerGreen;
    localparam int InnerDivBlue   = 255 - InnerBlue;

    localparam int BorderRecipRed   = (RecipOne + 2 * BorderDivRed - 1) / (2 * BorderDivRed);
    localparam int BorderRecipGreen =
        (RecipOne + 2 * BorderDivGreen - 1) / (2 * BorderDivGreen);
    localparam int BorderRecipBlue  = (RecipOne + 2 * BorderDivBlue - 1) / (2 * BorderDivBlue);
    localparam int InnerRecipRed    = (RecipOne + 2 * InnerDivRed - 1) / (2 * InnerDivRed);
    localparam int InnerRecipGreen  = (RecipOne + 2 * InnerDivGreen - 1) / (2 * InnerDivGreen);
    localparam int InnerRecipBlue   = (RecipOne + 2 * InnerDivBlue - 1) / (2 * InnerDivBlue);

    // Three 8-bit color lanes, red in lane 0.
    typedef logic [2:0][7:0] color_t;

    // Pixel after classification.
    typedef struct packed {
        logic   border;
        color_t color;
    } class_t;

    // Pixel with its computed alpha.
    typedef struct packed {
        logic [7:0] alpha;
        color_t     color;
    } alpha_t;

    // Base color of one channel.
    function automatic logic [7:0] base_color(input logic border, input logic [1:0] ch);
        logic [7:0] v;
        case (ch)
            CH_RED:   v = border ? 8'(BorderRed)   : 8'(InnerRed);
            CH_GREEN: v = border ? 8'(BorderGreen) : 8'(InnerGreen);
            CH_BLUE:  v = border ? 8'(BorderBlue)  : 8'(InnerBlue);
            default:  v = 8'd0;
        endcase
        return v;
    endfunction

    // Coverage divisor of one channel, 255 minus the base color.
    function automatic logic [7:0] chan_div(input logic border, input logic [1:0] ch);
        logic [7:0] v;
        case (ch)
            CH_RED:   v = border ? 8'(BorderDivRed)   : 8'(InnerDivRed);
            CH_GREEN: v = border ? 8'(BorderDivGreen) : 8'(InnerDivGreen);
            CH_BLUE:  v = border ? 8'(BorderDivBlue)  : 8'(InnerDivBlue);
            default:  v = 8'd1;
        endcase
        return v;
    endfunction

    // Reciprocal of twice the coverage divisor.
    function automatic logic [15:0] chan_recip(input logic border, input logic [1:0] ch);
        logic [15:0] v;
        case (ch)
            CH_RED:   v = border ? 16'(BorderRecipRed)   : 16'(InnerRecipRed);
            CH_GREEN: v = border ? 16'(BorderRecipGreen) : 16'(InnerRecipGreen);
            CH_BLUE:  v = border ? 16'(BorderRecipBlue)  : 16'(InnerRecipBlue);
            default:  v = 16'd0;
        endcase
        return v;
    endfunction

    // Base alpha of the class.
    function automatic logic [7:0] base_alpha(input logic border);
        return border ? 8'(BorderAlpha) : 8'(InnerAlpha);
    endfunction

    // Alpha span from the base alpha up to the text alpha.
    function automatic logic [5:0] alpha_span(input logic border);
        return border ? 6'(TextAlpha - BorderAlpha) : 6'(TextAlpha - InnerAlpha);
    endfunction

endpackage

// ===== design/hca_border.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hca_border
// Holds the frame size registers and classes each pixel as border or
// interior in one register stage.
// ---------------------------------------------------------------------------
module hca_border #(
    parameter int COORD_BITS = 10
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_index,
    input  logic [hca_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [COORD_BITS-1:0]        in_col,
    input  logic [COORD_BITS-1:0]        in_row,
    input  hca_pkg::color_t              in_color,
    output logic                         out_valid,
    input  logic                         out_ready,
    output hca_pkg::class_t              out_data
);

    localparam int CmpW = ((COORD_BITS > hca_pkg::CFG_W) ? COORD_BITS : hca_pkg::CFG_W) + 1;

    logic [hca_pkg::CFG_W-1:0] frame_width_reg;
    logic [hca_pkg::CFG_W-1:0] frame_height_reg;
    logic [CmpW-1:0]           last_col;
    logic [CmpW-1:0]           last_row;
    logic                      border_next;
    logic                      valid_reg;
    hca_pkg::class_t           data_reg;

    // Configuration writes; an unknown index leaves both registers alone.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= hca_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= hca_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                hca_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data;
                hca_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // A zero frame size has no last column or row, so it never matches.
    always_comb begin
        last_col    = CmpW'(frame_width_reg) - CmpW'(1);
        last_row    = CmpW'(frame_height_reg) - CmpW'(1);
        border_next = (in_col == '0) || (in_row == '0) ||
                      ((frame_width_reg != '0) && (CmpW'(in_col) == last_col)) ||
                      ((frame_height_reg != '0) && (CmpW'(in_row) == last_row));
    end

    assign in_ready = !valid_reg || out_ready;

    // Classification stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg.border <= border_next;
            data_reg.color  <= in_color;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/hca_alpha.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hca_alpha
// Three stages: scaled coverage numerators, reciprocal multiply, then the
// largest rounded raise added to the base alpha.
// ---------------------------------------------------------------------------
module hca_alpha (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  hca_pkg::class_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output hca_pkg::alpha_t out_data
);

    // Stage one: numerator 2 * n * span + d of each channel.
    logic            num_valid_reg;
    logic            num_ready;
    hca_pkg::class_t num_class_reg;
    logic [14:0]     num_reg [3];
    logic [14:0]     num_next [3];

    // Stage two: numerator times reciprocal.
    logic            prod_valid_reg;
    logic            prod_ready;
    hca_pkg::class_t prod_class_reg;
    logic [30:0]     prod_reg [3];
    logic [30:0]     prod_next [3];

    // Stage three: alpha.
    logic            alpha_valid_reg;
    logic            alpha_ready;
    hca_pkg::alpha_t alpha_reg;
    logic [7:0]      alpha_next;

    assign alpha_ready = !alpha_valid_reg || out_ready;
    assign prod_ready  = !prod_valid_reg || alpha_ready;
    assign num_ready   = !num_valid_reg || prod_ready;
    assign in_ready    = num_ready;

    // Coverage numerators; a channel below its base contributes nothing.
    always_comb begin
        logic [7:0]  base;
        logic [7:0]  over;
        logic [13:0] scaled;
        for (int i = 0; i < 3; i++) begin
            base   = hca_pkg::base_color(in_data.border, 2'(i));
            over   = (in_data.color[i] > base) ? (in_data.color[i] - base) : 8'd0;
            scaled = 14'(over) * 14'(hca_pkg::alpha_span(in_data.border));
            num_next[i] = {scaled, 1'b0} + 15'(hca_pkg::chan_div(in_data.border, 2'(i)));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_valid_reg <= 1'b0;
        end else if (num_ready) begin
            num_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (num_ready && in_valid) begin
            num_class_reg <= in_data;
            for (int i = 0; i < 3; i++) begin
                num_reg[i] <= num_next[i];
            end
        end
    end

    // Division by 2 * d done as a multiply by its rounded-up reciprocal.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod_next[i] = 31'(num_reg[i]) *
                           31'(hca_pkg::chan_recip(num_class_reg.border, 2'(i)));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (prod_ready) begin
            prod_valid_reg <= num_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && num_valid_reg) begin
            prod_class_reg <= num_class_reg;
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= prod_next[i];
            end
        end
    end

    // Largest raise over the three channels, added to the base alpha.
    always_comb begin
        logic [5:0] raise_max;
        logic [5:0] raise_ch;
        raise_max = 6'd0;
        for (int i = 0; i < 3; i++) begin
            raise_ch = prod_reg[i][hca_pkg::RECIP_SHIFT+5:hca_pkg::RECIP_SHIFT];
            if (raise_ch > raise_max) begin
                raise_max = raise_ch;
            end
        end
        alpha_next = hca_pkg::base_alpha(prod_class_reg.border) + 8'(raise_max);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_valid_reg <= 1'b0;
        end else if (alpha_ready) begin
            alpha_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (alpha_ready && prod_valid_reg) begin
            alpha_reg.alpha <= alpha_next;
            alpha_reg.color <= prod_class_reg.color;
        end
    end

    assign out_valid = alpha_valid_reg;
    assign out_data  = alpha_reg;

endmodule

// ===== design/hca_premul.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hca_premul
// Two stages: c * a + 127 per channel, then the division by 255 done with
// shifts and adds.
// ---------------------------------------------------------------------------
module hca_premul (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  hca_pkg::alpha_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output hca_pkg::alpha_t out_data
);

    logic            mul_valid_reg;
    logic            mul_ready;
    logic [7:0]      mul_alpha_reg;
    logic [15:0]     mul_reg [3];
    logic [15:0]     mul_next [3];

    logic            div_valid_reg;
    logic            div_ready;
    hca_pkg::alpha_t div_reg;
    hca_pkg::color_t div_next;

    assign div_ready = !div_valid_reg || out_ready;
    assign mul_ready = !mul_valid_reg || div_ready;
    assign in_ready  = mul_ready;

    // Rounded products; the largest is 255 * 238 + 127 and fits 16 bits.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mul_next[i] = 16'(in_data.color[i]) * 16'(in_data.alpha) + 16'd127;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (mul_ready) begin
            mul_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && in_valid) begin
            mul_alpha_reg <= in_data.alpha;
            for (int i = 0; i < 3; i++) begin
                mul_reg[i] <= mul_next[i];
            end
        end
    end

    // floor(v / 255) = (v + 1 + (v >> 8)) >> 8, exact for v below 65535.
    always_comb begin
        logic [16:0] acc;
        for (int i = 0; i < 3; i++) begin
            acc         = 17'(mul_reg[i]) + 17'd1 + 17'(mul_reg[i][15:8]);
            div_next[i] = acc[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_valid_reg <= 1'b0;
        end else if (div_ready) begin
            div_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_ready && mul_valid_reg) begin
            div_reg.alpha <= mul_alpha_reg;
            div_reg.color <= div_next;
        end
    end

    assign out_valid = div_valid_reg;
    assign out_data  = div_reg;

endmodule

// ===== design/hud_coverage_alpha_premultiply.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hud_coverage_alpha_premultiply
// Turns straight overlay pixels into premultiplied pixels with an alpha
// raised by text coverage.
// ---------------------------------------------------------------------------
// Usage:
// Pixels enter on the s_ stream: column, row and straight red, green, blue.
// Each pixel leaves on the m_ stream as premultiplied red, green, blue and
// its alpha, in order, one result for every request.
// The frame size registers (index 0 width, index 1 height), written on the
// cfg_wr_ port, decide which pixels belong to the border. The user must
// write them only while no pixel is in flight; the block does not enforce it.
// An accepted request reaches m_tvalid through the register stages: one
// stage to class the pixel, three for the coverage numerator, the reciprocal
// multiply and the alpha, two for the premultiply and its division by 255.
// Throughput is one pixel per clock while m_tready stays high; every stage is
// a register with its own valid bit.
// When the receiver stalls, each stage holds its request and passes ready
// back only when it is empty or its successor moves, so bubbles are filled
// before s_tready falls.
// A synchronous reset empties the pipeline and sets the frame to 420 by 80.
// ---------------------------------------------------------------------------
`include "hud_coverage_alpha_premultiply_assert.svh"

module hud_coverage_alpha_premultiply #(
    parameter int COORD_BITS = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Configuration write port.
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_index,
    input  logic [hca_pkg::CFG_W-1:0] cfg_wr_data,
    // Input pixels.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // Fields from bit 0: pixel_col, pixel_row, in_red, in_green, in_blue, zero fill.
    input  logic [((2*COORD_BITS+24+7)/8)*8-1:0] s_tdata,
    // Result pixels.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // Fields from bit 0: out_red, out_green, out_blue, out_alpha.
    output logic [31:0]               m_tdata
);

    localparam int ColorLsb = 2 * COORD_BITS;

    logic [COORD_BITS-1:0] in_col;
    logic [COORD_BITS-1:0] in_row;
    hca_pkg::color_t       in_color;

    logic                  class_valid;
    logic                  class_ready;
    hca_pkg::class_t       class_data;
    logic                  alpha_valid;
    logic                  alpha_ready;
    hca_pkg::alpha_t       alpha_data;
    hca_pkg::alpha_t       result;
    logic                  alpha_in_range;
    logic                  premul_in_bound;

    // Unpack the input request.
    assign in_col   = s_tdata[COORD_BITS-1:0];
    assign in_row   = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_color = s_tdata[ColorLsb+23:ColorLsb];

    hca_border #(
        .COORD_BITS (COORD_BITS)
    ) u_border (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_col       (in_col),
        .in_row       (in_row),
        .in_color     (in_color),
        .out_valid    (class_valid),
        .out_ready    (class_ready),
        .out_data     (class_data)
    );

    hca_alpha u_alpha (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (class_valid),
        .in_ready  (class_ready),
        .in_data   (class_data),
        .out_valid (alpha_valid),
        .out_ready (alpha_ready),
        .out_data  (alpha_data)
    );

    hca_premul u_premul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (alpha_valid),
        .in_ready  (alpha_ready),
        .in_data   (alpha_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    // Pack the result request.
    assign m_tdata = {result.alpha, result.color};

    // Range checks on the outgoing request.
    assign alpha_in_range  = (result.alpha >= 8'(hca_pkg::InnerAlpha)) &&
                             (result.alpha <= 8'(hca_pkg::TextAlpha));
    assign premul_in_bound = (result.color[0] <= result.alpha) &&
                             (result.color[1] <= result.alpha) &&
                             (result.color[2] <= result.alpha);

    // Alpha always lies between the interior base and the text alpha.
    `HCA_ASSERT_IMPLY(a_alpha_range, aclk, aresetn, m_tvalid, alpha_in_range)
    // A premultiplied channel never exceeds its alpha.
    `HCA_ASSERT_IMPLY(a_premul_bound, aclk, aresetn, m_tvalid, premul_in_bound)
    // An empty output stage means no stage can hold back the input.
    `HCA_ASSERT_IMPLY(a_ready_when_drained, aclk, aresetn, !m_tvalid, s_tready)
    // A reset cycle leaves the pipeline empty and ready.
    `HCA_ASSERT_NEXT(a_empty_after_reset, aclk, 1'b1, !aresetn, !m_tvalid && s_tready)

endmodule
